>>> sv/tkft_pkg.sv
`timescale 1ns / 1ps

package tkft_pkg;

  // Port field widths are fixed; internal storage may be narrower.
  localparam int ID_PORT_BITS    = 16;
  localparam int COUNT_PORT_BITS = 16;

  typedef struct packed {
    logic [ID_PORT_BITS-1:0]    candidate_id;
    logic [COUNT_PORT_BITS-1:0] candidate_count;
    logic                       last_candidate;
  } cand_t;

  typedef struct packed {
    logic [ID_PORT_BITS-1:0]    out_id;
    logic [COUNT_PORT_BITS-1:0] out_count;
    logic                       found;
    logic                       last_result;
  } result_t;

endpackage

>>> sv/tkft_slot_ram.sv
`timescale 1ns / 1ps

module tkft_slot_ram #(
  parameter int DEPTH = 10,
  parameter int IDW   = 16,
  parameter int CNTW  = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   wr_addr,
  input  logic [IDW-1:0]  wr_id,
  input  logic [CNTW-1:0] wr_count,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [IDW-1:0]  rd_id,
  output logic [CNTW-1:0] rd_count
);

  logic [IDW+CNTW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_id, wr_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_id, rd_count} <= mem[rd_addr];
    end
  end

endmodule

>>> sv/tkft_min_unit.sv
`timescale 1ns / 1ps

// Running minimum over a stream of counts; ties keep the earliest index.
module tkft_min_unit #(
  parameter int CNTW = 16,
  parameter int AW   = 4
) (
  input  logic            clk,
  input  logic            en,
  input  logic            first,
  input  logic [AW-1:0]   idx,
  input  logic [CNTW-1:0] value,
  output logic [CNTW-1:0] least,
  output logic [AW-1:0]   pick
);

  always_ff @(posedge clk) begin
    if (en) begin
      if (first || (value < least)) begin
        least <= value;
        pick  <= idx;
      end
    end
  end

endmodule

>>> sv/top_k_frequency_tracker.sv
`timescale 1ns / 1ps
// A candidate with zero count is dropped in S_IDLE, and one that finds a free slot is written there.
// A candidate against a full table scans every slot (S_SCAN, S_SCAN_END, S_DECIDE): the slot
// memory's single read port feeds one comparator, one slot per cycle.
// A report reads each kept entry, then loads the output register, waiting while out_stall holds it.
// Reset clears the fill count and control state; the slot memory is not cleared.
module top_k_frequency_tracker #(
  parameter int KEEP_SLOTS = 10,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tkft_pkg::cand_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tkft_pkg::result_t out_data
);

  localparam int IdW   = (ID_BITS < tkft_pkg::ID_PORT_BITS) ? ID_BITS
                                                            : tkft_pkg::ID_PORT_BITS;
  localparam int CntW  = (COUNT_BITS < tkft_pkg::COUNT_PORT_BITS) ? COUNT_BITS
                                                                 : tkft_pkg::COUNT_PORT_BITS;
  localparam int IdxW  = (KEEP_SLOTS > 1) ? $clog2(KEEP_SLOTS) : 1;
  localparam int UsedW = $clog2(KEEP_SLOTS + 1);
  localparam logic [UsedW-1:0] SlotsFull = UsedW'(KEEP_SLOTS);
  localparam logic [IdxW-1:0]  LastIdx   = IdxW'(KEEP_SLOTS - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SCAN_END = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_REP_READ = 3'd4;
  localparam logic [2:0] S_REP_LOAD = 3'd5;
  localparam logic [2:0] S_EMPTY    = 3'd6;

  logic [2:0]      state, state_next;
  logic [UsedW-1:0] used, used_next;
  logic [IdxW-1:0] addr, addr_next;
  logic [IdW-1:0]  cand_id;
  logic [CntW-1:0] cand_cnt;
  logic            cand_last;
  logic            scan_vld;
  logic [IdxW-1:0] scan_idx;

  logic            we;
  logic [IdxW-1:0] wr_addr;
  logic [IdW-1:0]  wr_id;
  logic [CntW-1:0] wr_count;
  logic            rd_en;
  logic [IdW-1:0]  rd_id;
  logic [CntW-1:0] rd_count;
  logic [CntW-1:0] least;
  logic [IdxW-1:0] pick;

  logic            in_acc;
  logic [IdW-1:0]  in_id;
  logic [CntW-1:0] in_cnt;
  logic            out_free;
  logic            out_load;
  tkft_pkg::result_t out_next;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_id    = in_data.candidate_id[IdW-1:0];
  assign in_cnt   = in_data.candidate_count[CntW-1:0];
  assign out_free = !out_valid || !out_stall;

  tkft_slot_ram #(
    .DEPTH (KEEP_SLOTS),
    .IDW   (IdW),
    .CNTW  (CntW),
    .AW    (IdxW)
  ) u_ram (
    .clk      (clk),
    .we       (we),
    .wr_addr  (wr_addr),
    .wr_id    (wr_id),
    .wr_count (wr_count),
    .rd_en    (rd_en),
    .rd_addr  (addr),
    .rd_id    (rd_id),
    .rd_count (rd_count)
  );

  tkft_min_unit #(
    .CNTW (CntW),
    .AW   (IdxW)
  ) u_min (
    .clk   (clk),
    .en    (scan_vld),
    .first (scan_idx == '0),
    .idx   (scan_idx),
    .value (rd_count),
    .least (least),
    .pick  (pick)
  );

  always_comb begin
    state_next = state;
    used_next  = used;
    addr_next  = addr;
    we         = 1'b0;
    wr_addr    = used[IdxW-1:0];
    wr_id      = in_id;
    wr_count   = in_cnt;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          addr_next = '0;
          if (in_cnt != '0 && used != SlotsFull) begin
            we        = 1'b1;
            used_next = used + 1'b1;
            if (in_data.last_candidate) begin
              state_next = S_REP_READ;
            end
          end else if (in_cnt != '0) begin
            state_next = S_SCAN;
          end else if (in_data.last_candidate) begin
            state_next = (used == '0) ? S_EMPTY : S_REP_READ;
          end
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (addr == LastIdx) begin
          state_next = S_SCAN_END;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      S_SCAN_END: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        wr_addr  = pick;
        wr_id    = cand_id;
        wr_count = cand_cnt;
        we       = (cand_cnt > least);
        addr_next  = '0;
        state_next = cand_last ? S_REP_READ : S_IDLE;
      end
      S_REP_READ: begin
        rd_en      = 1'b1;
        state_next = S_REP_LOAD;
      end
      S_REP_LOAD: begin
        out_next.out_id      = tkft_pkg::ID_PORT_BITS'(rd_id);
        out_next.out_count   = tkft_pkg::COUNT_PORT_BITS'(rd_count);
        out_next.found       = 1'b1;
        out_next.last_result = ((UsedW'(addr) + 1'b1) == used);
        if (out_free) begin
          out_load = 1'b1;
          if (out_next.last_result) begin
            used_next  = '0;
            state_next = S_IDLE;
          end else begin
            addr_next  = addr + 1'b1;
            state_next = S_REP_READ;
          end
        end
      end
      S_EMPTY: begin
        out_next.last_result = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      addr      <= '0;
      scan_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      addr     <= addr_next;
      scan_vld <= (state == S_SCAN);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= addr;
    if (in_acc) begin
      cand_id   <= in_id;
      cand_cnt  <= in_cnt;
      cand_last <= in_data.last_candidate;
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Fill count stays within the table.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= SlotsFull)
    else $error("fill count exceeds slot count");

  // Closing a report clears the fill count.
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.last_result) |=> (used == '0))
    else $error("fill count not cleared after report");

  // A not-found result is always the only one of its report.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> out_data.last_result)
    else $error("not-found result without last mark");

endmodule
